// ===== rtl/kbfd_pkg.sv =====
package kbfd_pkg;

    // Default sizing of the line store and the block
    localparam int DEF_MAX_OUT_SIZE = 1024;
    localparam int DEF_MAX_FACTOR   = 4;

    // Configuration map: register index taken from paddr[3:2]
    localparam int          ADDR_W         = 4;
    localparam logic [1:0]  REG_OUT_SIZE   = 2'd0;
    localparam logic [1:0]  REG_FACTOR     = 2'd1;
    localparam logic [1:0]  REG_KEY_COLOUR = 2'd2;

    // Register widths and reset values
    localparam int           OUT_SIZE_W       = 11;
    localparam int           FACTOR_W         = 3;
    localparam int           KEY_W            = 32;
    localparam logic [10:0]  OUT_SIZE_RESET   = 11'd16;
    localparam logic [2:0]   FACTOR_RESET     = 3'd4;
    localparam logic [31:0]  KEY_COLOUR_RESET = 32'h00FF00FF;

    // Divider lanes
    localparam int LANES      = 4;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_HOLD   = 4'b1000
    } kbfd_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the request and read its line store entry
        logic first;     // request opens a new block
        logic write;     // write back the entry and load the divider lanes
        logic div_step;  // advance every divider lane by one bit
        logic load_out;  // move the quotients into the output register
        logic blk_last;  // block under divide is the last of the frame
    } kbfd_cmd_t;

endpackage

// ===== rtl/keyed_box_filter_downsampler.sv =====
// A block-final pixel is captured with its line store entry, the entry is written
// back as the divider lanes load, the lanes divide bit-serially, and the quotients
// move to the output register once it is free or being taken. No new pixel is
// accepted until the last one is written back, or for a block-final pixel until
// its result is loaded. Reset clears the scan position, the controller and the
// output valid; the line store holds no reset value and is written before any value read from it is used.
module keyed_box_filter_downsampler
    import kbfd_pkg::*;
#(
    parameter int MAX_OUT_SIZE = DEF_MAX_OUT_SIZE,
    parameter int MAX_FACTOR   = DEF_MAX_FACTOR
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  logic [31:0]       pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [7:0]        alpha,
    output logic              last_of_frame
);

    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int SZW  = $clog2(MAX_OUT_SIZE + 1);
    localparam int COLW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
    localparam int CNTW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

    logic [OUT_SIZE_W-1:0] out_size_reg;
    logic [FACTOR_W-1:0]   factor_reg;
    logic [KEY_W-1:0]      key_reg;

    logic                  cfg_we;
    logic                  restart;
    logic [FW-1:0]         eff_factor;
    logic [SZW-1:0]        eff_size;
    logic [2*FW-1:0]       area_full;
    logic [CNTW-1:0]       area;
    logic [COLW-1:0]       col;
    kbfd_cmd_t             cmd;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign restart = cfg_we && ((paddr[3:2] == REG_OUT_SIZE) ||
                                (paddr[3:2] == REG_FACTOR) ||
                                (paddr[3:2] == REG_KEY_COLOUR));

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg <= OUT_SIZE_RESET;
            factor_reg   <= FACTOR_RESET;
            key_reg      <= KEY_COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_OUT_SIZE:   out_size_reg <= pwdata[OUT_SIZE_W-1:0];
                REG_FACTOR:     factor_reg   <= pwdata[FACTOR_W-1:0];
                REG_KEY_COLOUR: key_reg      <= pwdata[KEY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[3:2])
            REG_OUT_SIZE:   prdata = 32'(out_size_reg);
            REG_FACTOR:     prdata = 32'(factor_reg);
            REG_KEY_COLOUR: prdata = key_reg;
            default:        prdata = '0;
        endcase
    end

    // Clamp factor and size into their working ranges
    always_comb
    begin
        if (factor_reg == '0)
        begin
            eff_factor = FW'(1);
        end
        else if (int'(factor_reg) > MAX_FACTOR)
        begin
            eff_factor = FW'(MAX_FACTOR);
        end
        else
        begin
            eff_factor = FW'(factor_reg);
        end

        if (out_size_reg == '0)
        begin
            eff_size = SZW'(1);
        end
        else if (int'(out_size_reg) > MAX_OUT_SIZE)
        begin
            eff_size = SZW'(MAX_OUT_SIZE);
        end
        else
        begin
            eff_size = SZW'(out_size_reg);
        end

        area_full = {{FW{1'b0}}, eff_factor} * {{FW{1'b0}}, eff_factor};
        area      = area_full[CNTW-1:0];
    end

    kbfd_ctrl #(
        .MAX_OUT_SIZE (MAX_OUT_SIZE),
        .MAX_FACTOR   (MAX_FACTOR)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .restart      (restart),
        .eff_factor   (eff_factor),
        .eff_size     (eff_size),
        .col          (col),
        .cmd          (cmd)
    );

    kbfd_dp #(
        .MAX_OUT_SIZE (MAX_OUT_SIZE),
        .MAX_FACTOR   (MAX_FACTOR)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .col           (col),
        .pixel         (pixel),
        .key_colour    (key_reg),
        .area          (area),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_frame (last_of_frame)
    );

    // A block with no opaque pixel has zero coverage and black color
    a_empty_black: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (alpha == 8'd0) |-> (red == 8'd0) && (green == 8'd0) && (blue == 8'd0))
        else $error("empty block gives nonzero color");

    // Hold off the next request while the line store entry is written back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> pixel_stall)
        else $error("request accepted during write back");

    // A result is loaded only from the hold state
    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_stall))
        else $error("result loaded while accepting requests");

    // The output register never overwrites a result that still waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !result_valid || !result_stall)
        else $error("pending result overwritten");

endmodule

// ===== rtl/kbfd_ctrl.sv =====
module kbfd_ctrl
    import kbfd_pkg::*;
#(
    parameter int MAX_OUT_SIZE = DEF_MAX_OUT_SIZE,
    parameter int MAX_FACTOR   = DEF_MAX_FACTOR
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  logic                 restart,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]   eff_factor,
    input  logic [$clog2(MAX_OUT_SIZE+1)-1:0] eff_size,
    output logic [((MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1)-1:0] col,
    output kbfd_cmd_t            cmd
);

    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int SZW  = $clog2(MAX_OUT_SIZE + 1);
    localparam int SUBW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int COLW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
    localparam int CNTW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DW   = CNTW + 8;
    localparam int STW  = $clog2(DW);

    kbfd_state_t     state_reg, state_next;
    logic [SUBW-1:0] sub_col_reg, sub_col_next;
    logic [SUBW-1:0] sub_row_reg, sub_row_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [COLW-1:0] row_reg, row_next;
    logic            emit_reg, emit_next;
    logic            last_reg, last_next;
    logic            full_reg, full_next;
    logic [STW-1:0]  step_reg, step_next;

    logic            accept;
    logic            out_take;
    logic            last_sc, last_sr, last_col, last_row;
    logic [FW:0]     sc_inc, sr_inc;
    logic [SZW:0]    col_inc, row_inc;

    assign pixel_stall  = (state_reg != S_IDLE);
    assign result_valid = full_reg;
    assign accept       = pixel_valid && (state_reg == S_IDLE);
    assign out_take     = full_reg && !result_stall;
    assign col          = col_reg;

    // Scan position tests
    always_comb
    begin
        sc_inc   = (FW + 1)'(sub_col_reg) + (FW + 1)'(1);
        sr_inc   = (FW + 1)'(sub_row_reg) + (FW + 1)'(1);
        col_inc  = (SZW + 1)'(col_reg) + (SZW + 1)'(1);
        row_inc  = (SZW + 1)'(row_reg) + (SZW + 1)'(1);
        last_sc  = sc_inc >= {1'b0, eff_factor};
        last_sr  = sr_inc >= {1'b0, eff_factor};
        last_col = col_inc >= {1'b0, eff_size};
        last_row = row_inc >= {1'b0, eff_size};
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        emit_next    = emit_reg;
        last_next    = last_reg;
        step_next    = step_reg;
        full_next    = full_reg;
        cmd          = '0;
        cmd.first    = (sub_col_reg == '0) && (sub_row_reg == '0);
        cmd.blk_last = last_reg;

        if (out_take)
        begin
            full_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    emit_next   = last_sc && last_sr;
                    last_next   = last_col && last_row;
                    state_next  = S_UPDATE;
                    // advance the scan position
                    if (last_sc)
                    begin
                        sub_col_next = '0;
                        if (last_col)
                        begin
                            col_next = '0;
                            if (last_sr)
                            begin
                                sub_row_next = '0;
                                row_next     = last_row ? '0 : row_inc[COLW-1:0];
                            end
                            else
                            begin
                                sub_row_next = sr_inc[SUBW-1:0];
                            end
                        end
                        else
                        begin
                            col_next = col_inc[COLW-1:0];
                        end
                    end
                    else
                    begin
                        sub_col_next = sc_inc[SUBW-1:0];
                    end
                end
            end
            S_UPDATE:
            begin
                cmd.write  = 1'b1;
                step_next  = '0;
                state_next = emit_reg ? S_DIVIDE : S_IDLE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STW'(1);
                if (step_reg == STW'(DW - 1))
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!full_reg || out_take)
                begin
                    cmd.load_out = 1'b1;
                    full_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // return to the start of a frame on a write to a configuration register
        if (restart)
        begin
            sub_col_next = '0;
            sub_row_next = '0;
            col_next     = '0;
            row_next     = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            emit_reg    <= 1'b0;
            last_reg    <= 1'b0;
            step_reg    <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            emit_reg    <= emit_next;
            last_reg    <= last_next;
            step_reg    <= step_next;
            full_reg    <= full_next;
        end
    end

endmodule

// ===== rtl/kbfd_dp.sv =====
module kbfd_dp
    import kbfd_pkg::*;
#(
    parameter int MAX_OUT_SIZE = DEF_MAX_OUT_SIZE,
    parameter int MAX_FACTOR   = DEF_MAX_FACTOR
) (
    input  logic              clk,
    input  kbfd_cmd_t         cmd,
    input  logic [((MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1)-1:0] col,
    input  logic [31:0]       pixel,
    input  logic [KEY_W-1:0]  key_colour,
    input  logic [$clog2(MAX_FACTOR*MAX_FACTOR+1)-1:0] area,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [7:0]        alpha,
    output logic              last_of_frame
);

    localparam int COLW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
    localparam int CNTW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DW   = CNTW + 8;
    localparam int EW   = 3 * DW + CNTW;

    // Line store: {blue, green, red, count} per output column
    logic [EW-1:0]   line_mem [MAX_OUT_SIZE];

    logic [31:0]     pix_reg;
    logic            first_reg;
    logic [EW-1:0]   rd_reg;
    logic [COLW-1:0] wa_reg;
    logic [CNTW-1:0] cnt_reg;

    logic [DW-1:0]   quo_reg [LANES];
    logic [CNTW-1:0] rem_reg [LANES];
    logic [CNTW-1:0] dvs_reg [LANES];

    logic [7:0]      red_reg, green_reg, blue_reg, alpha_reg;
    logic            last_reg;

    logic            opaque;
    logic [DW-1:0]   inc_r, inc_g, inc_b;
    logic [CNTW-1:0] inc_n;
    logic [DW-1:0]   sum_r, sum_g, sum_b;
    logic [CNTW-1:0] cnt_next;
    logic [EW-1:0]   entry_next;
    logic [DW-1:0]   cnt_scaled;
    logic [DW-1:0]   quo_next [LANES];
    logic [CNTW-1:0] rem_next [LANES];
    logic [CNTW:0]   rsh      [LANES];
    logic [CNTW:0]   diff     [LANES];

    // Add the request to its column entry, or start the entry afresh
    always_comb
    begin
        opaque     = (pix_reg != key_colour);
        inc_r      = opaque ? DW'(pix_reg[7:0])   : '0;
        inc_g      = opaque ? DW'(pix_reg[15:8])  : '0;
        inc_b      = opaque ? DW'(pix_reg[23:16]) : '0;
        inc_n      = opaque ? CNTW'(1) : '0;
        if (first_reg)
        begin
            sum_r    = inc_r;
            sum_g    = inc_g;
            sum_b    = inc_b;
            cnt_next = inc_n;
        end
        else
        begin
            sum_b    = rd_reg[EW-1 -: DW] + inc_b;
            sum_g    = rd_reg[EW-DW-1 -: DW] + inc_g;
            sum_r    = rd_reg[EW-2*DW-1 -: DW] + inc_r;
            cnt_next = rd_reg[CNTW-1:0] + inc_n;
        end
        entry_next = {sum_b, sum_g, sum_r, cnt_next};
        // count * 255 for the coverage lane
        cnt_scaled = {cnt_next, 8'b0} - DW'(cnt_next);
    end

    // One restoring step per lane
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rsh[i] = {rem_reg[i], quo_reg[i][DW-1]};
            diff[i] = rsh[i] - {1'b0, dvs_reg[i]};
            if (!diff[i][CNTW])
            begin
                rem_next[i] = diff[i][CNTW-1:0];
                quo_next[i] = {quo_reg[i][DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rsh[i][CNTW-1:0];
                quo_next[i] = {quo_reg[i][DW-2:0], 1'b0};
            end
        end
    end

    // Capture the request and read its entry; write back the updated entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg   <= pixel;
            first_reg <= cmd.first;
            rd_reg    <= line_mem[col];
            wa_reg    <= col;
        end
        if (cmd.write)
        begin
            line_mem[wa_reg] <= entry_next;
        end
    end

    // Divider lanes
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            cnt_reg             <= cnt_next;
            quo_reg[LANE_RED]   <= sum_r;
            quo_reg[LANE_GREEN] <= sum_g;
            quo_reg[LANE_BLUE]  <= sum_b;
            quo_reg[LANE_ALPHA] <= cnt_scaled;
            dvs_reg[LANE_RED]   <= cnt_next;
            dvs_reg[LANE_GREEN] <= cnt_next;
            dvs_reg[LANE_BLUE]  <= cnt_next;
            dvs_reg[LANE_ALPHA] <= area;
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    // Output register; an empty block gives black
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            red_reg   <= (cnt_reg == '0) ? 8'd0 : quo_reg[LANE_RED][7:0];
            green_reg <= (cnt_reg == '0) ? 8'd0 : quo_reg[LANE_GREEN][7:0];
            blue_reg  <= (cnt_reg == '0) ? 8'd0 : quo_reg[LANE_BLUE][7:0];
            alpha_reg <= quo_reg[LANE_ALPHA][7:0];
            last_reg  <= cmd.blk_last;
        end
    end

    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha         = alpha_reg;
    assign last_of_frame = last_reg;

endmodule

// ===== tb/kbfd_checker.sv =====
module kbfd_checker
    import kbfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    input  logic              pixel_valid,
    input  logic              pixel_stall,
    input  logic [31:0]       pixel,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    input  logic [7:0]        alpha,
    input  logic              last_of_frame,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } rgba_t;

    // Shadow copy of the configuration registers
    logic [OUT_SIZE_W-1:0] size_reg;
    logic [FACTOR_W-1:0]   factor_reg;
    logic [KEY_W-1:0]      key_reg;

    // Column sums of the block row under way
    int col_red   [DEF_MAX_OUT_SIZE];
    int col_green [DEF_MAX_OUT_SIZE];
    int col_blue  [DEF_MAX_OUT_SIZE];
    int col_count [DEF_MAX_OUT_SIZE];

    // Scan position inside the frame
    int sub_col;
    int blk_col;
    int sub_row;
    int blk_row;

    rgba_t expected_rgba[$];
    rgba_t oldest;
    int    err_count;
    int    n_pending;

    assign errors  = err_count;
    assign pending = n_pending;

    function automatic int clamp_cfg(int value, int limit);
        if (value == 0)
        begin
            return 1;
        end
        return (value > limit) ? limit : value;
    endfunction

    task automatic restart_scan();
        sub_col = 0;
        blk_col = 0;
        sub_row = 0;
        blk_row = 0;
    endtask

    // Update the shadow register; only a mapped register restarts the frame
    task automatic apply_write(input logic [1:0] idx, input logic [31:0] data);
        bit hit;
        hit = 1'b1;
        case (idx)
            REG_OUT_SIZE:   size_reg   = data[OUT_SIZE_W-1:0];
            REG_FACTOR:     factor_reg = data[FACTOR_W-1:0];
            REG_KEY_COLOUR: key_reg    = data[KEY_W-1:0];
            default:        hit        = 1'b0;
        endcase
        if (hit)
        begin
            restart_scan();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic check_read(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_OUT_SIZE:   check_field("out_size read", 32'(size_reg), data);
            REG_FACTOR:     check_field("factor read", 32'(factor_reg), data);
            REG_KEY_COLOUR: check_field("key_colour read", 32'(key_reg), data);
            default:        ;
        endcase
    endtask

    // Accumulate one pixel into its column and queue the block result on its last pixel
    task automatic reduce_pixel(input logic [31:0] px);
        int    f;
        int    side;
        int    col;
        int    cnt;
        bit    opaque;
        rgba_t res;
        f      = clamp_cfg(int'(factor_reg), DEF_MAX_FACTOR);
        side   = clamp_cfg(int'(size_reg), DEF_MAX_OUT_SIZE);
        col    = (blk_col >= DEF_MAX_OUT_SIZE) ? DEF_MAX_OUT_SIZE - 1 : blk_col;
        opaque = (px != key_reg);

        if (sub_row == 0 && sub_col == 0)
        begin
            col_red[col]   = 0;
            col_green[col] = 0;
            col_blue[col]  = 0;
            col_count[col] = 0;
        end
        if (opaque)
        begin
            col_red[col]   += int'(px[7:0]);
            col_green[col] += int'(px[15:8]);
            col_blue[col]  += int'(px[23:16]);
            col_count[col] += 1;
        end

        if (sub_row + 1 >= f && sub_col + 1 >= f)
        begin
            cnt = col_count[col];
            res.red   = (cnt != 0) ? 8'(col_red[col] / cnt) : 8'd0;
            res.green = (cnt != 0) ? 8'(col_green[col] / cnt) : 8'd0;
            res.blue  = (cnt != 0) ? 8'(col_blue[col] / cnt) : 8'd0;
            res.alpha = 8'((cnt * 255) / (f * f));
            res.last  = (blk_row + 1 >= side) && (blk_col + 1 >= side);
            expected_rgba.push_back(res);
        end

        // Advance the scan position, wrapping at the end of the frame
        sub_col++;
        if (sub_col >= f)
        begin
            sub_col = 0;
            blk_col++;
            if (blk_col >= side)
            begin
                blk_col = 0;
                sub_row++;
                if (sub_row >= f)
                begin
                    sub_row = 0;
                    blk_row++;
                    if (blk_row >= side)
                    begin
                        blk_row = 0;
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   = OUT_SIZE_RESET;
            factor_reg = FACTOR_RESET;
            key_reg    = KEY_COLOUR_RESET;
            restart_scan();
            expected_rgba.delete();
            err_count  = 0;
            n_pending  = 0;
        end
        else
        begin
            // Register access phase
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    apply_write(paddr[3:2], pwdata);
                end
                else
                begin
                    check_read(paddr[3:2], prdata);
                end
            end

            // Accepted pixel request
            if (pixel_valid && !pixel_stall)
            begin
                reduce_pixel(pixel);
            end

            // Accepted result: compare with the oldest expected block
            if (result_valid && !result_stall)
            begin
                if (expected_rgba.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %0h %0h %0h %0h %0b",
                             $time, red, green, blue, alpha, last_of_frame);
                    err_count++;
                end
                else
                begin
                    oldest = expected_rgba.pop_front();
                    check_field("red", 32'(oldest.red), 32'(red));
                    check_field("green", 32'(oldest.green), 32'(green));
                    check_field("blue", 32'(oldest.blue), 32'(blue));
                    check_field("alpha", 32'(oldest.alpha), 32'(alpha));
                    check_field("last_of_frame", 32'(oldest.last), 32'(last_of_frame));
                end
            end
            n_pending = expected_rgba.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import kbfd_pkg::*;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         MAX_GAP        = 17;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              pixel_valid;
    logic              pixel_stall;
    logic [31:0]       pixel;
    logic              result_valid;
    logic              result_stall;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              last_of_frame;

    int errors;
    int pending;
    int idle_cycles;
    int rx_wait;
    bit rx_burst;
    bit tx_burst;

    keyed_box_filter_downsampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_frame (last_of_frame)
    );

    kbfd_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_frame (last_of_frame),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: draw a stall length after every accepted result
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rx_burst = !rx_burst;
            end
            rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            result_stall <= 1'b1;
            rx_wait--;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (psel && penable))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("tb: errors");
        $finish;
    end

    // One register access: setup cycle, then access cycle until pready
    task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] side, input logic [31:0] fac,
                              input logic [31:0] key);
        wait_idle();
        reg_access(1'b1, REG_OUT_SIZE, side);
        reg_access(1'b1, REG_FACTOR, fac);
        reg_access(1'b1, REG_KEY_COLOUR, key);
        reg_access(1'b0, REG_OUT_SIZE, 32'd0);
        reg_access(1'b0, REG_FACTOR, 32'd0);
        reg_access(1'b0, REG_KEY_COLOUR, 32'd0);
    endtask

    // Send one pixel request after a random gap, hold it until accepted
    task automatic send_pixel(input logic [31:0] px);
        int gap;
        if ($urandom_range(0, 49) == 0)
        begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
            pixel       <= $urandom;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_pixel(input logic [31:0] key, input int key_pct);
        int roll;
        if ($urandom_range(0, 99) < key_pct)
        begin
            return key;
        end
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return key ^ (32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Configure, stream a run of pixels; optionally pause mid-run for an idle check
    task automatic run_phase(input logic [31:0] side, input logic [31:0] fac,
                             input logic [31:0] key, input int npix, input int key_pct,
                             input int pause_at);
        set_config(side, fac, key);
        for (int i = 0; i < npix; i++)
        begin
            if (i == pause_at)
            begin
                // Drain fully, then poke the unmapped register: scan must carry on
                wait_idle();
                reg_access(1'b1, REG_SPARE, $urandom);
            end
            send_pixel(pick_pixel(key, key_pct));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        result_stall = 1'b0;
        rx_wait      = 0;
        rx_burst     = 1'b0;
        tx_burst     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: a few pixels that complete no block
        send_pixel(KEY_COLOUR_RESET);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);

        // One pixel per frame: every pixel is a block and the end of a frame
        set_config(32'd1, 32'd1, KEY_COLOUR_RESET);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(KEY_COLOUR_RESET);
        send_pixel(32'hFF00_0000);
        send_pixel(32'h0012_3456);
        send_pixel(32'h01FF_00FF);

        // Two by two blocks: fully keyed, saturated, and mixed coverage
        set_config(32'd1, 32'd2, KEY_COLOUR_RESET);
        repeat (4) send_pixel(KEY_COLOUR_RESET);
        repeat (4) send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h00FF_FFFF);
        send_pixel(KEY_COLOUR_RESET);
        send_pixel(32'h0080_4020);

        // Random phases over the register extremes
        run_phase(32'd2, 32'd4, $urandom, 64, 30, -1);
        run_phase(32'd3, 32'd2, 32'h0000_0000, 72, 50, -1);
        run_phase(32'd0, 32'd0, 32'hFFFF_FFFF, 30, 40, -1);
        run_phase(32'd1, 32'd7, $urandom, 48, 95, -1);
        run_phase(32'd2047, 32'd1, $urandom, 40, 20, -1);
        run_phase(32'd4, 32'd3, $urandom, 144, 25, -1);
        run_phase(32'd1024, 32'd1, $urandom, 700, 10, 600);

        wait_idle();
        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kbfd_pkg.sv
rtl/kbfd_ctrl.sv
rtl/kbfd_dp.sv
rtl/keyed_box_filter_downsampler.sv
tb/kbfd_checker.sv
tb/tb.sv
